// ===== design/srf_pkg.sv =====
// srf_pkg: shared types and codes for the systolic row feeder
// no dependencies; every other file of the feeder except srf_ram imports it

package srf_pkg;

	// fixed widths of the channel payloads
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;

	// input operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_FORWARD = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FEED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STORED  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SLICE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_EN = 4'd1;

	// per-transaction result info from the controller
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                mark;
		logic                block_end;
		logic                from_mem;
	} res_info_t;

	// controller status flags
	typedef struct packed {
		logic fill_full;
		logic drain_ready;
	} ctrl_stat_t;

endpackage

// ===== design/srf_in_if.sv =====
// srf_in_if: input channel of the feeder (load and drain requests)
// depends on srf_pkg

interface srf_in_if
	import srf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              op;
	logic [WORD_W-1:0] word_data;
	logic              new_pair;

	modport source (output valid, op, word_data, new_pair, input ready);
	modport sink (input valid, op, word_data, new_pair, output ready);
endinterface

// ===== design/srf_out_if.sv =====
// srf_out_if: result channel of the feeder
// depends on srf_pkg

interface srf_out_if
	import srf_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   out_data;
	logic                out_new_pair;
	logic                block_end;

	modport source (output valid, status, out_data, out_new_pair, block_end, input ready);
	modport sink (input valid, status, out_data, out_new_pair, block_end, output ready);
endinterface

// ===== design/srf_cfg_if.sv =====
// srf_cfg_if: configuration write channel of the feeder
// depends on srf_pkg

interface srf_cfg_if
	import srf_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/systolic_row_feeder_pingpong.sv =====
// systolic_row_feeder_pingpong: top level of the double-buffered row feeder
// depends on srf_pkg, srf_in_if, srf_out_if, srf_cfg_if, srf_ram, srf_ctrl

// Takes one transaction per clock unless the result channel stalls and gives one
// result per transaction via stage 1 and the output register. Both banks live in
// one ram of 2*ROWS_PER_BLOCK*COLS_PER_BLOCK words with one write and one registered
// read port: kept-slice loads write the fill bank at acceptance, drains read the
// other bank at acceptance and the read data joins the result in the output register.
// Banks swap in the same cycle that the fill completes if the drain bank is idle.
// No clearing pass follows reset; draining a never-loaded word returns undefined
// data. Configuration is written through cfg at any time and is taken every cycle.

module systolic_row_feeder_pingpong
	import srf_pkg::*;
#(
	parameter int SLICES = 4,
	parameter int ROWS_PER_BLOCK = 4,
	parameter int COLS_PER_BLOCK = 8,
	parameter int REPEATS = 4,
	parameter int DATA_WIDTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	srf_in_if.sink      in_ch,
	srf_out_if.source   out_ch,
	srf_cfg_if.sink     cfg
);

	localparam int BANK_WORDS = ROWS_PER_BLOCK * COLS_PER_BLOCK;
	localparam int DEPTH = 2 * BANK_WORDS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [1:0]            keep_slice_q;
	logic                  forward_enable_q;
	logic                  accept;
	logic                  ram_we, ram_re;
	logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [DATA_WIDTH-1:0] word;
	res_info_t             info;
	ctrl_stat_t            stat;
	logic                  v_s1;
	res_info_t             info_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic                  s1_go;
	logic                  out_v_q;
	logic [STATUS_W-1:0]   status_q;
	logic [WORD_W-1:0]     data_q;
	logic                  mark_q;
	logic                  end_q;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_slice_q     <= 2'd0;
			forward_enable_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_KEEP_SLICE: keep_slice_q <= cfg.data[1:0];
				CFG_FORWARD_EN: forward_enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or drains
	assign s1_go       = !out_v_q || out_ch.ready;
	assign in_ch.ready = !v_s1 || s1_go;
	assign accept      = in_ch.valid && in_ch.ready;
	assign word        = in_ch.word_data[DATA_WIDTH-1:0];

	srf_ctrl #(
		.SLICES(SLICES),
		.ROWS_PER_BLOCK(ROWS_PER_BLOCK),
		.COLS_PER_BLOCK(COLS_PER_BLOCK),
		.REPEATS(REPEATS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.op(in_ch.op),
		.new_pair(in_ch.new_pair),
		.keep_slice(keep_slice_q),
		.forward_enable(forward_enable_q),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.info(info),
		.stat(stat)
	);

	srf_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_bank_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(word),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// stage 1: result waiting for the ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			data_s1 <= (info.status == ST_FORWARD) ? word : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && v_s1) begin
			status_q <= info_s1.status;
			data_q   <= WORD_W'(info_s1.from_mem ? ram_rdata : data_s1);
			mark_q   <= info_s1.mark;
			end_q    <= info_s1.block_end;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.status       = status_q;
	assign out_ch.out_data     = data_q;
	assign out_ch.out_new_pair = mark_q;
	assign out_ch.block_end    = end_q;

`ifndef SYNTH
	// fill writes and drain reads always target different banks
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("fill write and drain read hit the same ram word");

	// a complete fill bank only waits while a drain block is pending
	a_full_waits: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill_full |-> stat.drain_ready)
		else $error("fill bank full while no drain is pending");

	// finishing a fill block leaves a drain block ready
	a_fill_swap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.op == OP_LOAD && info.block_end |=> stat.drain_ready)
		else $error("no drain block ready after a completed fill");
`endif

endmodule

// ===== design/srf_ram.sv =====
// srf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module srf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/srf_ctrl.sv =====
// srf_ctrl: fill and drain counters, bank swap and ram addressing of the feeder
// depends on srf_pkg

module srf_ctrl
	import srf_pkg::*;
#(
	parameter int SLICES = 4,
	parameter int ROWS_PER_BLOCK = 4,
	parameter int COLS_PER_BLOCK = 8,
	parameter int REPEATS = 4,
	localparam int BANK_WORDS = ROWS_PER_BLOCK * COLS_PER_BLOCK,
	localparam int ADDR_W = $clog2(2 * BANK_WORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              op,
	input  logic              new_pair,
	input  logic [1:0]        keep_slice,
	input  logic              forward_enable,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	output res_info_t         info,
	output ctrl_stat_t        stat
);

	localparam int SLW = (SLICES > 1) ? $clog2(SLICES) : 1;
	localparam int PW  = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
	localparam int RPW = (REPEATS > 1) ? $clog2(REPEATS) : 1;
	localparam int RW  = (ROWS_PER_BLOCK > 1) ? $clog2(ROWS_PER_BLOCK) : 1;
	localparam int CW  = (COLS_PER_BLOCK > 1) ? $clog2(COLS_PER_BLOCK) : 1;

	logic [SLW-1:0] slice_q, slice_n;
	logic [PW-1:0]  pos_q, pos_n;
	logic [RPW-1:0] rep_q, rep_n;
	logic [RW-1:0]  row_q, row_n;
	logic [CW-1:0]  col_q, col_n;
	logic           full_q, full_n;
	logic           dready_q, dready_n;
	logic           fmark_q, fmark_n;
	logic           dmark_q, dmark_n;
	logic           bank_q, bank_n;
	logic [ADDR_W-1:0] fill_idx, drain_idx;

	// bank-local indexes into the shared ram
	always_comb begin
		fill_idx  = ADDR_W'(pos_q);
		drain_idx = ADDR_W'(row_q) * ADDR_W'(COLS_PER_BLOCK) + ADDR_W'(col_q);
		ram_waddr = bank_q ? fill_idx + ADDR_W'(BANK_WORDS) : fill_idx;
		ram_raddr = bank_q ? drain_idx : drain_idx + ADDR_W'(BANK_WORDS);
	end

	// next state and result of one transaction
	always_comb begin
		slice_n  = slice_q;
		pos_n    = pos_q;
		rep_n    = rep_q;
		row_n    = row_q;
		col_n    = col_q;
		full_n   = full_q;
		dready_n = dready_q;
		fmark_n  = fmark_q;
		dmark_n  = dmark_q;
		bank_n   = bank_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		info     = '{status: ST_EMPTY, mark: 1'b0, block_end: 1'b0, from_mem: 1'b0};
		if (accept) begin
			if (op == OP_LOAD) begin
				if (full_q) begin
					info.status = ST_REJECT;
				end else begin
					ram_we  = (32'(slice_q) == 32'(keep_slice));
					fmark_n = new_pair;
					if (pos_q == PW'(BANK_WORDS - 1)) begin
						pos_n = '0;
						if (slice_q == SLW'(SLICES - 1)) begin
							slice_n = '0;
							full_n = 1'b1;
							info.block_end = 1'b1;
						end else begin
							slice_n = slice_q + 1'b1;
						end
					end else begin
						pos_n = pos_q + 1'b1;
					end
					info.status = forward_enable ? ST_FORWARD : ST_STORED;
					info.mark   = forward_enable & new_pair;
				end
			end else if (dready_q) begin
				ram_re        = 1'b1;
				info.status   = ST_FEED;
				info.from_mem = 1'b1;
				// only the first column of a block carries the mark
				info.mark     = dmark_q && (col_q == '0);
				if (rep_q == RPW'(REPEATS - 1)) begin
					rep_n = '0;
					if (row_q == RW'(ROWS_PER_BLOCK - 1)) begin
						row_n = '0;
						if (col_q == CW'(COLS_PER_BLOCK - 1)) begin
							col_n = '0;
							info.block_end = 1'b1;
							dready_n = 1'b0;
							dmark_n = 1'b0;
						end else begin
							col_n = col_q + 1'b1;
						end
					end else begin
						row_n = row_q + 1'b1;
					end
				end else begin
					rep_n = rep_q + 1'b1;
				end
			end
		end
		// swap banks once the fill is complete and the drain is done
		if (full_n && !dready_n) begin
			dready_n = 1'b1;
			dmark_n  = fmark_n;
			fmark_n  = 1'b0;
			full_n   = 1'b0;
			bank_n   = ~bank_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q  <= '0;
			pos_q    <= '0;
			rep_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			full_q   <= 1'b0;
			dready_q <= 1'b0;
			fmark_q  <= 1'b0;
			dmark_q  <= 1'b0;
			bank_q   <= 1'b0;
		end else begin
			slice_q  <= slice_n;
			pos_q    <= pos_n;
			rep_q    <= rep_n;
			row_q    <= row_n;
			col_q    <= col_n;
			full_q   <= full_n;
			dready_q <= dready_n;
			fmark_q  <= fmark_n;
			dmark_q  <= dmark_n;
			bank_q   <= bank_n;
		end
	end

	assign stat = '{fill_full: full_q, drain_ready: dready_q};

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for the double-buffered systolic row feeder
// depends on srf_pkg, srf_in_if, srf_out_if, srf_cfg_if and systolic_row_feeder_pingpong

module tb_top;
	import srf_pkg::*;

	localparam int SLICES = 4;
	localparam int ROWS_PER_BLOCK = 4;
	localparam int COLS_PER_BLOCK = 8;
	localparam int REPEATS = 4;
	localparam int DATA_WIDTH = 64;

	localparam int BANK_WORDS = ROWS_PER_BLOCK * COLS_PER_BLOCK;
	localparam int FILL_WORDS = SLICES * BANK_WORDS;
	localparam int DRAIN_WORDS = BANK_WORDS * REPEATS;
	localparam int MARKED_WORDS = ROWS_PER_BLOCK * REPEATS;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 40;
	localparam int IDLE_PCT = 9;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   data;
		logic                mark;
		logic                blk_end;
	} feeder_result_t;

	// feeder behavior model plus the queue of results still owed by the block
	class feeder_scoreboard;
		logic [WORD_W-1:0] bank_words [2][BANK_WORDS];
		bit                fill_bank;
		int unsigned       fill_count;
		int unsigned       drain_count;
		bit                drain_ready;
		bit                fill_mark;
		bit                drain_mark;
		logic [1:0]        keep_slice;
		bit                forward_en;
		feeder_result_t    feeder_results_due[$];
		int                mismatches;

		function new();
			fill_bank = 1'b0;
			fill_count = 0;
			drain_count = 0;
			drain_ready = 1'b0;
			fill_mark = 1'b0;
			drain_mark = 1'b0;
			keep_slice = 2'd0;
			forward_en = 1'b1;
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				CFG_KEEP_SLICE: keep_slice = val[1:0];
				CFG_FORWARD_EN: forward_en = val[0];
				default: ;
			endcase
		endfunction

		// one load or drain request, returns the result the block owes for it
		function feeder_result_t feed_step(logic op, logic [WORD_W-1:0] word, logic np);
			feeder_result_t r;
			int unsigned row;
			int unsigned col;
			r.status = ST_EMPTY;
			r.data = '0;
			r.mark = 1'b0;
			r.blk_end = 1'b0;
			if (op == OP_LOAD) begin
				if (fill_count >= FILL_WORDS) begin
					r.status = ST_REJECT;
				end else begin
					// only the kept slice lands in the fill bank
					if (fill_count / BANK_WORDS == keep_slice)
						bank_words[fill_bank][fill_count % BANK_WORDS] = word;
					fill_mark = np;
					fill_count++;
					r.blk_end = (fill_count == FILL_WORDS);
					if (forward_en) begin
						r.status = ST_FORWARD;
						r.data = word;
						r.mark = np;
					end else begin
						r.status = ST_STORED;
					end
				end
			end else if (drain_ready) begin
				// column outermost, then row, each word repeated
				row = (drain_count / REPEATS) % ROWS_PER_BLOCK;
				col = drain_count / (REPEATS * ROWS_PER_BLOCK);
				r.status = ST_FEED;
				r.data = bank_words[!fill_bank][row * COLS_PER_BLOCK + col];
				r.mark = drain_mark && (drain_count < MARKED_WORDS);
				drain_count++;
				if (drain_count >= DRAIN_WORDS) begin
					r.blk_end = 1'b1;
					drain_count = 0;
					drain_ready = 1'b0;
					drain_mark = 1'b0;
				end
			end
			// bank swap once the fill is full and the drain side is free
			if (fill_count >= FILL_WORDS && !drain_ready) begin
				drain_ready = 1'b1;
				drain_mark = fill_mark;
				fill_mark = 1'b0;
				fill_count = 0;
				drain_count = 0;
				fill_bank = !fill_bank;
			end
			return r;
		endfunction

		function logic [STATUS_W-1:0] note_request(logic op, logic [WORD_W-1:0] word, logic np);
			feeder_result_t r;
			r = feed_step(op, word, np);
			feeder_results_due.push_back(r);
			return r.status;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch: %s", what);
		endtask

		task check_result(feeder_result_t got);
			feeder_result_t want;
			if (feeder_results_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d", got.status));
				return;
			end
			want = feeder_results_due.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
			if (got.data !== want.data)
				report_mismatch($sformatf("out_data %h, wanted %h", got.data, want.data));
			if (got.mark !== want.mark)
				report_mismatch($sformatf("out_new_pair %b, wanted %b", got.mark, want.mark));
			if (got.blk_end !== want.blk_end)
				report_mismatch($sformatf("block_end %b, wanted %b", got.blk_end, want.blk_end));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             rx_ready = 1'b0;
	bit               no_idle;
	int unsigned      cycle_count;
	int unsigned      items_done;
	feeder_result_t   seen_result;
	feeder_scoreboard sb;

	srf_in_if  in_ch ();
	srf_out_if out_ch ();
	srf_cfg_if cfg_ch ();

	assign out_ch.ready = rx_ready;

	systolic_row_feeder_pingpong #(
		.SLICES(SLICES),
		.ROWS_PER_BLOCK(ROWS_PER_BLOCK),
		.COLS_PER_BLOCK(COLS_PER_BLOCK),
		.REPEATS(REPEATS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls at random, except in the quiet stretch
	always @(posedge clk) begin
		rx_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// result transactions, sampled mid-cycle when the handshake is stable
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen_result.status = out_ch.status;
			seen_result.data = out_ch.out_data;
			seen_result.mark = out_ch.out_new_pair;
			seen_result.blk_end = out_ch.block_end;
			sb.check_result(seen_result);
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one input transaction, then maybe a one-cycle gap
	task automatic send_request(logic op, logic [WORD_W-1:0] word, logic np);
		bit                  took;
		logic [STATUS_W-1:0] st;
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.word_data <= word;
		in_ch.new_pair <= np;
		do begin
			@(negedge clk);
			took = (in_ch.ready === 1'b1);
			@(posedge clk);
		end while (!took);
		st = sb.note_request(op, word, np);
		if (st != ST_REJECT && st != ST_EMPTY)
			items_done++;
		if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// mostly well-formed traffic, with some rejected loads and empty drains
	task automatic random_request();
		logic op;
		bit   can_load;
		bit   can_drain;
		can_load = (sb.fill_count < FILL_WORDS);
		can_drain = sb.drain_ready;
		if (can_load && can_drain)
			op = $urandom_range(0, 1) ? OP_DRAIN : OP_LOAD;
		else
			op = can_load ? OP_LOAD : OP_DRAIN;
		if ($urandom_range(0, 99) < 10)
			op = (op == OP_LOAD) ? OP_DRAIN : OP_LOAD;
		send_request(op, random_word(), 1'($urandom_range(0, 1)));
	endtask

	// run the fill side to a block boundary so the kept slice may change
	task automatic finish_block();
		while (sb.fill_count != 0)
			send_request((sb.fill_count < FILL_WORDS) ? OP_LOAD : OP_DRAIN, random_word(),
				1'($urandom_range(0, 1)));
	endtask

	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		while (sb.feeder_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		bit took;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do begin
			@(negedge clk);
			took = (cfg_ch.ready === 1'b1);
			@(posedge clk);
		end while (!took);
		sb.set_register(idx, val);
	endtask

	// register writes carry random upper data bits
	task automatic configure(bit with_slice, logic [1:0] slice, logic fwd);
		logic [CFG_DAT_W-1:0] junk;
		junk = CFG_DAT_W'($urandom);
		if (with_slice)
			cfg_write(CFG_KEEP_SLICE, {junk[CFG_DAT_W-1:2], slice});
		cfg_write(CFG_FORWARD_EN, {junk[CFG_DAT_W-1:1], fwd});
		cfg_ch.valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int unsigned target;
		sb = new();
		arst_n = 1'b0;
		no_idle = 1'b0;
		items_done = 0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_LOAD;
		in_ch.word_data = '0;
		in_ch.new_pair = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_KEEP_SLICE;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: drain before anything is loaded, data extremes, both marks
		send_request(OP_DRAIN, '0, 1'b0);
		send_request(OP_LOAD, '0, 1'b0);
		send_request(OP_LOAD, '1, 1'b1);
		send_request(OP_LOAD, {32{2'b01}}, 1'b0);
		send_request(OP_LOAD, {32{2'b10}}, 1'b1);
		send_request(OP_LOAD, 64'd1, 1'b1);
		send_request(OP_LOAD, {1'b1, 63'd0}, 1'b0);
		wait_quiet();

		// directed: last feeder keeps words without forwarding
		configure(1'b0, 2'd0, 1'b0);
		send_request(OP_LOAD, '1, 1'b1);
		send_request(OP_LOAD, '0, 1'b0);
		send_request(OP_DRAIN, '1, 1'b1);
		wait_quiet();
		configure(1'b0, 2'd0, 1'b1);

		// random phases; kept slice only changes on a block boundary
		for (int p = 0; p < PHASES; p++) begin
			no_idle = (p == 3);
			target = items_done + PHASE_ITEMS;
			while (items_done < target)
				random_request();
			if (p == 1 || p == 4)
				finish_block();
			wait_quiet();
			configure(p == 1 || p == 4, 2'(3 - p / 2), p % 2 == 1);
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
